[design/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int unsigned CELL_W    = 16;
  localparam int unsigned ATTR_W    = 8;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned COL_W     = 7;
  localparam int unsigned ROW_W     = 5;
  localparam int unsigned ACTION_W  = 2;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUT_CUR = 2'd0,
    ACT_PUT_POS = 2'd1,
    ACT_CLEAR   = 2'd2,
    ACT_READ    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL
  } state_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic [CHAR_W-1:0] char_code;
    action_t           action;
  } item_t;

  typedef struct packed {
    logic              scrolled;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic [CELL_W-1:0] cell_data;
  } res_t;

endpackage

[design/tcw_ram.sv]
// ----------------------------------------------------------------------------
// tcw_ram
// Generic RAM, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/tcw_ctrl.sv]
// ----------------------------------------------------------------------------
// tcw_ctrl
// Cursor logic and screen sequencer: cell writes, reads, scroll copy and
// blank fill, all through the screen RAM.
// ----------------------------------------------------------------------------
module tcw_ctrl #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  tcw_pkg::item_t                         in_item,
  output logic                                   in_ready,
  input  logic                                   out_free,
  input  logic [tcw_pkg::ATTR_W-1:0]             attr,
  output logic                                   done,
  output tcw_pkg::res_t                          res,
  output logic                                   mem_we,
  output logic [$clog2(COLUMNS*ROWS)-1:0]        mem_waddr,
  output logic [tcw_pkg::CELL_W-1:0]             mem_wdata,
  output logic [$clog2(COLUMNS*ROWS)-1:0]        mem_raddr,
  input  logic [tcw_pkg::CELL_W-1:0]             mem_rdata
);
  import tcw_pkg::*;

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CNT_W = $clog2(CELLS + 1);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic              scr_r, scr_nxt;
  logic              inside_r, inside_nxt;

  logic              accept;
  logic [CNT_W-1:0]  cur_addr;
  logic [CNT_W-1:0]  tgt_addr;
  logic [CNT_W-1:0]  copy_waddr;
  logic              on_screen;
  logic              is_nl;
  logic              wrap;
  logic              at_last_row;

  assign in_ready    = (state_r == ST_IDLE) && out_free;
  assign accept      = in_valid && in_ready;
  assign cur_addr    = CNT_W'(row_r) * CNT_W'(COLUMNS) + CNT_W'(col_r);
  assign tgt_addr    = CNT_W'(in_item.row) * CNT_W'(COLUMNS) + CNT_W'(in_item.column);
  assign copy_waddr  = cnt_r - CNT_W'(COLUMNS + 1);
  assign on_screen   = (in_item.column < COL_W'(COLUMNS)) && (in_item.row < ROW_W'(ROWS));
  assign is_nl       = (in_item.char_code == NEWLINE_CODE);
  assign wrap        = is_nl || (col_r == COL_W'(COLUMNS - 1));
  assign at_last_row = (row_r == ROW_W'(ROWS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_INIT;
      cnt_r    <= '0;
      row_r    <= '0;
      col_r    <= '0;
      scr_r    <= 1'b0;
      inside_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      scr_r    <= scr_nxt;
      inside_r <= inside_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    scr_nxt       = scr_r;
    inside_nxt    = inside_r;
    mem_we        = 1'b0;
    mem_waddr     = cur_addr[AW-1:0];
    mem_wdata     = {attr, in_item.char_code};
    mem_raddr     = tgt_addr[AW-1:0];
    done          = 1'b0;
    res.cell_data = '0;
    res.scrolled  = 1'b0;

    case (state_r)
      ST_INIT: begin
        // power-up clear uses the reset attribute
        mem_we    = 1'b1;
        mem_waddr = cnt_r[AW-1:0];
        mem_wdata = {RESET_ATTR, BLANK_CODE};
        if (cnt_r == CNT_W'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_item.action)
            ACT_PUT_CUR: begin
              mem_we = !is_nl;
              if (wrap) begin
                col_nxt = '0;
                if (at_last_row) begin
                  state_nxt = ST_SCROLL;
                  cnt_nxt   = CNT_W'(COLUMNS);
                  scr_nxt   = 1'b1;
                end else begin
                  row_nxt = row_r + 1'b1;
                  done    = 1'b1;
                end
              end else begin
                col_nxt = col_r + 1'b1;
                done    = 1'b1;
              end
            end
            ACT_PUT_POS: begin
              mem_we    = on_screen;
              mem_waddr = tgt_addr[AW-1:0];
              done      = 1'b1;
            end
            ACT_CLEAR: begin
              state_nxt = ST_FILL;
              cnt_nxt   = '0;
              scr_nxt   = 1'b0;
            end
            ACT_READ: begin
              state_nxt  = ST_READ;
              inside_nxt = on_screen;
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        done          = 1'b1;
        res.cell_data = inside_r ? mem_rdata : '0;
        state_nxt     = ST_IDLE;
      end
      ST_SCROLL: begin
        // read cell cnt, write the one fetched last cycle one row up
        mem_raddr = cnt_r[AW-1:0];
        mem_we    = (cnt_r > CNT_W'(COLUMNS));
        mem_waddr = copy_waddr[AW-1:0];
        mem_wdata = mem_rdata;
        if (cnt_r == CNT_W'(CELLS)) begin
          state_nxt = ST_FILL;
          cnt_nxt   = CNT_W'(CELLS - COLUMNS);
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[AW-1:0];
        mem_wdata = {attr, BLANK_CODE};
        if (cnt_r == CNT_W'(CELLS - 1)) begin
          done         = 1'b1;
          res.scrolled = scr_r;
          state_nxt    = ST_IDLE;
          cnt_nxt      = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    res.cursor_row    = row_nxt;
    res.cursor_column = col_nxt;
  end

endmodule

[design/text_console_writer_top.sv]
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text console: COLUMNS x ROWS screen of attribute/character cells with cursor.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  stream: one action per transfer (put at cursor, put at position,
//         clear screen, read cell). out_* stream: one result per action with
//         the read cell, the cursor after the action and a scrolled flag.
//   cfg_* channel: writes the text attribute; always ready. Write it only
//         while no action is in flight.
//   From accept to result in the output register:
//     put at cursor / put at position: one item per cycle unless out_* stalls
//     read cell: through the registered RAM read
//     clear screen: one RAM write per cycle over all COLUMNS*ROWS cells
//     put that scrolls: copy up one row through the RAM's
//       read and write port, then blank fill of the bottom row
//   Reset: a clearing pass writes every cell to a blank in attribute 7;
//   in_tready stays low meanwhile.
//   A stalled receiver holds the result in the output register; one more
//   action is taken per cycle only while that register is free or drains.
// ----------------------------------------------------------------------------
module text_console_writer_top #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] action, [9:2] char_code, [16:10] column_in, [21:17] row_in
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] cell_data, [20:16] cursor_row_out, [27:21] cursor_column_out,
  // [28] scrolled
  output logic [31:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import tcw_pkg::*;

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);

  logic [ATTR_W-1:0] attr_r;
  logic              out_valid_r;
  res_t              out_res_r;

  item_t             item;
  logic              done;
  res_t              res;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  assign item       = item_t'(in_tdata[$bits(item_t)-1:0]);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(32 - $bits(res_t)){1'b0}}, out_res_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r      <= RESET_ATTR;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        attr_r <= cfg_data;
      end
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_res_r <= res;
    end
  end

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_item   (item),
    .in_ready  (in_tready),
    .out_free  (!out_valid_r || out_tready),
    .attr      (attr_r),
    .done      (done),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
